[design/bvs_pkg.sv]
// Shared field widths, request and status codes, and sequencer states for the vector store.
package bvs_pkg;

    // Field widths of the stream payloads
    localparam int ACTION_W    = 3;
    localparam int INDEX_W     = 8;
    localparam int VALUE_W     = 32;
    localparam int RVAL_W      = 32;
    localparam int LEN_W       = 9;
    localparam int STAT_W      = 2;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_PAD_W   = OUT_TDATA_W - RVAL_W - LEN_W - STAT_W;

    // Request codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_GET    = 3'd0,
        ACT_SET    = 3'd1,
        ACT_APPEND = 3'd2,
        ACT_REMOVE = 3'd3,
        ACT_POP    = 3'd4
    } action_t;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SH_RD,
        S_SH_WR,
        S_RESP
    } state_t;

endpackage

[design/bvs_mem.sv]
// Entry storage: one write port, one read port, registered read data.
module bvs_mem #(
    parameter int DEPTH      = 256,
    parameter int WORD_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WORD_WIDTH-1:0]    wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WORD_WIDTH-1:0]    rdata
);

    logic [WORD_WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[design/bvs_ctrl.sv]
// Request sequencer: length count, read-modify-write of the entry memory, output register.
module bvs_ctrl #(
    parameter int DEPTH      = 256,
    parameter int WORD_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [bvs_pkg::IN_TDATA_W-1:0]        s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [bvs_pkg::OUT_TDATA_W-1:0]       m_tdata,
    output logic                                  mem_we,
    output logic [$clog2(DEPTH)-1:0]              mem_waddr,
    output logic [WORD_WIDTH-1:0]                 mem_wdata,
    output logic                                  mem_re,
    output logic [$clog2(DEPTH)-1:0]              mem_raddr,
    input  logic [WORD_WIDTH-1:0]                 mem_rdata
);

    import bvs_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMP_W = CW + INDEX_W;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [AW-1:0]          ptr_reg, ptr_next;
    logic [WORD_WIDTH-1:0]  res_value_reg, res_value_next;
    status_t                res_status_reg, res_status_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    action_t                act;
    logic [INDEX_W-1:0]     idx;
    logic [VALUE_W-1:0]     value_in;
    logic [AW-1:0]          idx_addr;
    logic                   accept;
    logic                   idx_in_range;
    logic                   remove_more;
    logic                   shift_more;
    logic                   store_full;
    logic                   store_empty;
    logic                   out_free;

    // Unpack the request
    assign act      = action_t'(s_tdata[ACTION_W-1:0]);
    assign idx      = s_tdata[ACTION_W +: INDEX_W];
    assign value_in = s_tdata[ACTION_W+INDEX_W +: VALUE_W];
    assign idx_addr = AW'(idx);

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Range and fill checks
    assign idx_in_range = CMP_W'(idx) < CMP_W'(count_reg);
    assign remove_more  = (CMP_W'(idx) + CMP_W'(1)) < CMP_W'(count_reg);
    assign shift_more   = ((CW+1)'(ptr_reg) + (CW+1)'(2)) < (CW+1)'(count_reg);
    assign store_full   = (count_reg == CW'(DEPTH));
    assign store_empty  = (count_reg == '0);
    assign out_free     = !out_valid_reg || m_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RESP;
                    if ((act == ACT_GET && idx_in_range) || (act == ACT_POP && !store_empty))
                    begin
                        state_next = S_READ;
                    end
                    else if (act == ACT_REMOVE && idx_in_range && remove_more)
                    begin
                        state_next = S_SH_RD;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_RESP;
            end
            S_SH_RD:
            begin
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                state_next = shift_more ? S_SH_RD : S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory accesses, count update and result capture
    always_comb
    begin
        mem_we          = 1'b0;
        mem_waddr       = ptr_reg;
        mem_wdata       = mem_rdata;
        mem_re          = 1'b0;
        mem_raddr       = AW'((CW+1)'(ptr_reg) + (CW+1)'(1));
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_value_next  = '0;
                    res_status_next = ST_OK;
                    unique case (act)
                        ACT_GET:
                        begin
                            if (idx_in_range)
                            begin
                                mem_re    = 1'b1;
                                mem_raddr = idx_addr;
                            end
                            else
                            begin
                                res_status_next = ST_RANGE;
                            end
                        end
                        ACT_SET:
                        begin
                            if (idx_in_range)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = idx_addr;
                                mem_wdata = WORD_WIDTH'(value_in);
                            end
                            else
                            begin
                                res_status_next = ST_RANGE;
                            end
                        end
                        ACT_APPEND:
                        begin
                            if (store_full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = AW'(count_reg);
                                mem_wdata  = WORD_WIDTH'(value_in);
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (idx_in_range)
                            begin
                                ptr_next = idx_addr;
                                if (!remove_more)
                                begin
                                    count_next = count_reg - CW'(1);
                                end
                            end
                            else
                            begin
                                res_status_next = ST_RANGE;
                            end
                        end
                        ACT_POP:
                        begin
                            if (store_empty)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(count_reg - CW'(1));
                            end
                        end
                        default:
                        begin
                            // Unused codes: no change, plain ok result
                            res_status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_value_next = mem_rdata;
            end
            S_SH_RD:
            begin
                mem_re = 1'b1;
            end
            S_SH_WR:
            begin
                // Move the next entry down one place
                mem_we   = 1'b1;
                ptr_next = AW'((CW+1)'(ptr_reg) + (CW+1)'(1));
                if (!shift_more)
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {OUT_PAD_W'(0), res_status_reg, LEN_W'(count_reg),
                                      RVAL_W'(res_value_reg)};
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[design/bounded_vector_store_unit.sv]
// Bounded vector store: DEPTH words in a single-port-pair RAM plus a length count. One request
// per transfer (get, set, append, remove with shift, pop), one result transfer per request.
// Set, append and all refused requests go straight to the result state; get and pop pass
// through a read state because the RAM read data is registered; a remove shifts each later
// entry down one place with one RAM read and one RAM write per entry. A new request is taken
// once the previous result sits in the output register, even if it has not been taken yet.
module bounded_vector_store_unit #(
    parameter int DEPTH      = 256,
    parameter int WORD_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [2:0] action, [10:3] index, [42:11] value, [47:43] zero
    input  logic [bvs_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] read_value, [40:32] length, [42:41] status, [47:43] zero
    output logic [bvs_pkg::OUT_TDATA_W-1:0] m_tdata
);

    import bvs_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [WORD_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [WORD_WIDTH-1:0] mem_rdata;

    logic [RVAL_W-1:0]     out_rval;
    logic [LEN_W-1:0]      out_len;
    logic [STAT_W-1:0]     out_stat;

    // Sequencer
    bvs_ctrl #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // Entry storage
    bvs_mem #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Split the result for checking
    assign out_rval = m_tdata[RVAL_W-1:0];
    assign out_len  = m_tdata[RVAL_W +: LEN_W];
    assign out_stat = m_tdata[RVAL_W+LEN_W +: STAT_W];

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (17'(out_len) <= 17'(DEPTH)))
        else $error("result length exceeds capacity");

    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_stat == ST_FULL) |-> (out_len == LEN_W'(DEPTH)))
        else $error("full status on a store that is not full");

    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_stat == ST_EMPTY) |-> (out_len == '0))
        else $error("empty status on a store that is not empty");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_stat != ST_OK) |-> (out_rval == '0))
        else $error("refused request returned data");
`endif

endmodule
